>>> design/windowed_traffic_limiter_defines.svh
// Assertion macros used by the checker file of the limiter.
`ifndef WINDOWED_TRAFFIC_LIMITER_DEFINES_SVH
`define WINDOWED_TRAFFIC_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_traffic_limiter: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_traffic_limiter: check failed");

`endif

>>> design/wtl_pkg.sv
package wtl_pkg;

    // Event kinds carried in the input tuser.
    typedef enum logic [1:0] {
        KIND_INGRESS = 2'd0,
        KIND_EGRESS  = 2'd1,
        KIND_CREATE  = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    // Drop reasons reported with each result.
    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_BYTES   = 3'd1,
        REASON_PACKETS = 3'd2,
        REASON_DNS     = 3'd3,
        REASON_FLOWS   = 3'd4,
        REASON_RAW     = 3'd5
    } reason_t;

    // Register indexes; register i sits at byte address 8*i.
    typedef enum logic [2:0] {
        REG_INGRESS_BYTE_LIMIT    = 3'd0,
        REG_EGRESS_BYTE_LIMIT     = 3'd1,
        REG_INGRESS_PACKET_LIMIT  = 3'd2,
        REG_EGRESS_PACKET_LIMIT   = 3'd3,
        REG_NEW_FLOW_LIMIT        = 3'd4,
        REG_DNS_QUERY_LIMIT       = 3'd5,
        REG_CONCURRENT_FLOW_LIMIT = 3'd6,
        REG_WINDOW_LENGTH_NS      = 3'd7
    } reg_idx_t;

    localparam int unsigned PADDR_W = 6;
    localparam int unsigned PDATA_W = 64;

    localparam logic [15:0] DNS_PORT    = 16'd53;
    localparam logic [15:0] FAMILY_V4   = 16'd2;
    localparam logic [15:0] FAMILY_V6   = 16'd10;
    localparam logic [15:0] TYPE_STREAM = 16'd1;
    localparam logic [15:0] TYPE_DGRAM  = 16'd2;
    localparam logic [63:0] DEFAULT_WINDOW_NS = 64'd1000000000;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int unsigned IN_TDATA_W  = 152;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [63:0] ingress_byte_limit;
        logic [63:0] egress_byte_limit;
        logic [63:0] ingress_packet_limit;
        logic [63:0] egress_packet_limit;
        logic [63:0] new_flow_limit;
        logic [63:0] dns_query_limit;
        logic [31:0] concurrent_flow_limit;
        logic [63:0] window_length_ns;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] timestamp_ns;
        logic [31:0] packet_length;
        logic [15:0] remote_port;
        logic [15:0] address_family;
        logic [15:0] socket_type;
        logic        flow_recorded;
        logic        flow_tracked;
    } event_t;

    typedef struct packed {
        logic    allowed;
        reason_t deny_code;
    } result_t;

endpackage

>>> design/wtl_cfg_regs.sv
module wtl_cfg_regs
    import wtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register file, written in the access phase of a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ingress_byte_limit    <= '0;
            cfg_reg.egress_byte_limit     <= '0;
            cfg_reg.ingress_packet_limit  <= '0;
            cfg_reg.egress_packet_limit   <= '0;
            cfg_reg.new_flow_limit        <= '0;
            cfg_reg.dns_query_limit       <= '0;
            cfg_reg.concurrent_flow_limit <= '0;
            cfg_reg.window_length_ns      <= DEFAULT_WINDOW_NS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_INGRESS_BYTE_LIMIT:    cfg_reg.ingress_byte_limit    <= pwdata;
                REG_EGRESS_BYTE_LIMIT:     cfg_reg.egress_byte_limit     <= pwdata;
                REG_INGRESS_PACKET_LIMIT:  cfg_reg.ingress_packet_limit  <= pwdata;
                REG_EGRESS_PACKET_LIMIT:   cfg_reg.egress_packet_limit   <= pwdata;
                REG_NEW_FLOW_LIMIT:        cfg_reg.new_flow_limit        <= pwdata;
                REG_DNS_QUERY_LIMIT:       cfg_reg.dns_query_limit       <= pwdata;
                REG_CONCURRENT_FLOW_LIMIT: cfg_reg.concurrent_flow_limit <= pwdata[31:0];
                REG_WINDOW_LENGTH_NS:      cfg_reg.window_length_ns      <= pwdata;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_INGRESS_BYTE_LIMIT:    prdata = cfg_reg.ingress_byte_limit;
            REG_EGRESS_BYTE_LIMIT:     prdata = cfg_reg.egress_byte_limit;
            REG_INGRESS_PACKET_LIMIT:  prdata = cfg_reg.ingress_packet_limit;
            REG_EGRESS_PACKET_LIMIT:   prdata = cfg_reg.egress_packet_limit;
            REG_NEW_FLOW_LIMIT:        prdata = cfg_reg.new_flow_limit;
            REG_DNS_QUERY_LIMIT:       prdata = cfg_reg.dns_query_limit;
            REG_CONCURRENT_FLOW_LIMIT: prdata = {32'd0, cfg_reg.concurrent_flow_limit};
            REG_WINDOW_LENGTH_NS:      prdata = cfg_reg.window_length_ns;
        endcase
    end

endmodule

>>> design/wtl_engine.sv
module wtl_engine
    import wtl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  event_t  ev,
    input  cfg_t    cfg,
    output result_t res
);

    logic [63:0] window_start_reg,   window_start_next;
    logic [63:0] ingress_byte_reg,   ingress_byte_next;
    logic [63:0] egress_byte_reg,    egress_byte_next;
    logic [63:0] ingress_packet_reg, ingress_packet_next;
    logic [63:0] egress_packet_reg,  egress_packet_next;
    logic [63:0] new_flow_reg,       new_flow_next;
    logic [63:0] dns_query_reg,      dns_query_next;
    logic [31:0] open_flow_reg,      open_flow_next;

    logic        early;
    logic        expired;
    logic [63:0] elapsed;
    logic        socket_ok;
    logic        roll_en;
    logic [63:0] ib_base, eb_base, ip_base, ep_base, nf_base, dq_base;
    logic        ingress_room, egress_room;
    reason_t     reason;

    // Window: early non-release events are denied; elapsed windows restart.
    assign early   = ev.timestamp_ns < window_start_reg;
    assign elapsed = ev.timestamp_ns - window_start_reg;
    assign expired = !early && (elapsed >= cfg.window_length_ns);

    assign socket_ok = ((ev.address_family == FAMILY_V4) || (ev.address_family == FAMILY_V6))
                    && ((ev.socket_type == TYPE_STREAM) || (ev.socket_type == TYPE_DGRAM));

    // Counters as seen after a possible window restart.
    assign ib_base = expired ? 64'd0 : ingress_byte_reg;
    assign eb_base = expired ? 64'd0 : egress_byte_reg;
    assign ip_base = expired ? 64'd0 : ingress_packet_reg;
    assign ep_base = expired ? 64'd0 : egress_packet_reg;
    assign nf_base = expired ? 64'd0 : new_flow_reg;
    assign dq_base = expired ? 64'd0 : dns_query_reg;

    // Byte budget: base plus length must stay within the limit.
    assign ingress_room = ({1'b0, ib_base} + {33'd0, ev.packet_length})
                       <= {1'b0, cfg.ingress_byte_limit};
    assign egress_room  = ({1'b0, eb_base} + {33'd0, ev.packet_length})
                       <= {1'b0, cfg.egress_byte_limit};

    // Decision and next state for the event in the input register.
    always_comb
    begin
        window_start_next   = window_start_reg;
        ingress_byte_next   = ingress_byte_reg;
        egress_byte_next    = egress_byte_reg;
        ingress_packet_next = ingress_packet_reg;
        egress_packet_next  = egress_packet_reg;
        new_flow_next       = new_flow_reg;
        dns_query_next      = dns_query_reg;
        open_flow_next      = open_flow_reg;
        reason              = REASON_NONE;

        roll_en = (ev.kind == KIND_INGRESS) || (ev.kind == KIND_EGRESS)
               || ((ev.kind == KIND_CREATE) && socket_ok);

        if (roll_en && expired)
        begin
            window_start_next   = ev.timestamp_ns;
            ingress_byte_next   = '0;
            egress_byte_next    = '0;
            ingress_packet_next = '0;
            egress_packet_next  = '0;
            new_flow_next       = '0;
            dns_query_next      = '0;
        end

        unique case (ev.kind)
            KIND_INGRESS:
            begin
                priority if (early || !ingress_room)
                    reason = REASON_BYTES;
                else if (ip_base >= cfg.ingress_packet_limit)
                    reason = REASON_PACKETS;
                else
                begin
                    ingress_byte_next   = ib_base + {32'd0, ev.packet_length};
                    ingress_packet_next = ip_base + 64'd1;
                end
            end
            KIND_EGRESS:
            begin
                // A DNS credit is taken first and stays spent.
                if (ev.remote_port == DNS_PORT)
                begin
                    if (early || (dq_base >= cfg.dns_query_limit))
                        reason = REASON_DNS;
                    else if (cfg.window_length_ns == 64'd0)
                        dns_query_next = '0;
                    else
                        dns_query_next = dq_base + 64'd1;
                end
                if (reason == REASON_NONE)
                begin
                    priority if (early || !egress_room)
                        reason = REASON_BYTES;
                    else if (ep_base >= cfg.egress_packet_limit)
                        reason = REASON_PACKETS;
                    else
                    begin
                        egress_byte_next   = eb_base + {32'd0, ev.packet_length};
                        egress_packet_next = ep_base + 64'd1;
                    end
                end
            end
            KIND_CREATE:
            begin
                priority if (!socket_ok)
                    reason = REASON_RAW;
                else if (!early && (nf_base < cfg.new_flow_limit)
                         && (open_flow_reg < cfg.concurrent_flow_limit))
                begin
                    // A failed flow record rolls the open count back.
                    new_flow_next = nf_base + 64'd1;
                    if (ev.flow_recorded)
                        open_flow_next = open_flow_reg + 32'd1;
                    else
                        reason = REASON_FLOWS;
                end
                else
                    reason = REASON_FLOWS;
            end
            KIND_RELEASE:
            begin
                if (ev.flow_tracked && (open_flow_reg != 32'd0))
                    open_flow_next = open_flow_reg - 32'd1;
            end
        endcase

        res.allowed   = (reason == REASON_NONE);
        res.deny_code = reason;
    end

    // Limiter state, updated once per processed event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg   <= '0;
            ingress_byte_reg   <= '0;
            egress_byte_reg    <= '0;
            ingress_packet_reg <= '0;
            egress_packet_reg  <= '0;
            new_flow_reg       <= '0;
            dns_query_reg      <= '0;
            open_flow_reg      <= '0;
        end
        else if (fire)
        begin
            window_start_reg   <= window_start_next;
            ingress_byte_reg   <= ingress_byte_next;
            egress_byte_reg    <= egress_byte_next;
            ingress_packet_reg <= ingress_packet_next;
            egress_packet_reg  <= egress_packet_next;
            new_flow_reg       <= new_flow_next;
            dns_query_reg      <= dns_query_next;
            open_flow_reg      <= open_flow_next;
        end
    end

endmodule

>>> design/windowed_traffic_limiter.sv
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     event: tuser kind, tdata fields
// m_axis    out        m_axis_tvalid/tready     result: allowed, deny_code
// apb       in         psel/penable, pready=1   eight limit and window registers
//
// One event per cycle sustained while the result side is ready; each event passes
// through the input register, where a single pass of compares and adds decides it
// and updates the counters, and then the result register.
// Reset clears the counters and window start and loads the register defaults.
// A stalled result register holds its beat; the input register still takes one
// more event while the result waits, then s_axis_tready drops.
module windowed_traffic_limiter
    import wtl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [63:0] timestamp_ns, [95:64] packet_length, [111:96] remote_port,
    // [127:112] address_family, [143:128] socket_type, [144] flow_recorded,
    // [145] flow_tracked, [151:146] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] allowed, [3:1] deny_code, [7:4] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic    in_valid_reg;
    event_t  in_item_reg;
    event_t  in_item;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    cfg_t    cfg;
    logic    advance;
    logic    in_take;

    // Unpack the input beat.
    always_comb
    begin
        in_item.kind           = kind_t'(s_axis_tuser[1:0]);
        in_item.timestamp_ns   = s_axis_tdata[63:0];
        in_item.packet_length  = s_axis_tdata[95:64];
        in_item.remote_port    = s_axis_tdata[111:96];
        in_item.address_family = s_axis_tdata[127:112];
        in_item.socket_type    = s_axis_tdata[143:128];
        in_item.flow_recorded  = s_axis_tdata[144];
        in_item.flow_tracked   = s_axis_tdata[145];
    end

    // The held event is processed when the result register can take it.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_res_reg.deny_code, out_res_reg.allowed};

    wtl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wtl_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ev    (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

endmodule

>>> design/wtl_checker.sv
`include "windowed_traffic_limiter_defines.svh"

module wtl_checker
    import wtl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A result is allowed exactly when it carries no drop reason.
    `WTL_ASSERT_NOW(a_allowed_matches_reason, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == 3'd0))

    // Drop reasons stay within the defined codes.
    `WTL_ASSERT_NOW(a_reason_in_range, m_axis_tvalid, m_axis_tdata[3:1] <= 3'd5)

    // The input side only backs up behind a stalled result.
    `WTL_ASSERT_NOW(a_backpressure_source, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // A stalled result beat holds.
    `WTL_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind windowed_traffic_limiter wtl_checker u_wtl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/wtl_verdict_checker.sv
`timescale 1ns / 100ps

// Watches the event, result and register channels of the limiter, predicts
// the verdict for every accepted event beat and compares it with the result
// beats in order.
module wtl_verdict_checker
    import wtl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic                   pready,
    output int                     mismatch_count,
    output int                     results_pending
);

    localparam bit INGRESS_DIR = 1'b0;
    localparam bit EGRESS_DIR  = 1'b1;

    // Limits as last written over the register port.
    logic [63:0] byte_cap [2];
    logic [63:0] packet_cap [2];
    logic [63:0] flow_cap;
    logic [63:0] dns_cap;
    logic [31:0] open_cap;
    logic [63:0] window_ns;

    // Accounting state of the subject.
    logic [63:0] window_base;
    logic [63:0] bytes_seen [2];
    logic [63:0] packets_seen [2];
    logic [63:0] flows_started;
    logic [63:0] dns_spent;
    logic [31:0] flows_open;

    result_t awaited_verdicts [$];
    int      errors;

    function automatic void clear_accounting();
        byte_cap[INGRESS_DIR]     = '0;
        byte_cap[EGRESS_DIR]      = '0;
        packet_cap[INGRESS_DIR]   = '0;
        packet_cap[EGRESS_DIR]    = '0;
        flow_cap                  = '0;
        dns_cap                   = '0;
        open_cap                  = '0;
        window_ns                 = DEFAULT_WINDOW_NS;
        window_base               = '0;
        bytes_seen[INGRESS_DIR]   = '0;
        bytes_seen[EGRESS_DIR]    = '0;
        packets_seen[INGRESS_DIR] = '0;
        packets_seen[EGRESS_DIR]  = '0;
        flows_started             = '0;
        dns_spent                 = '0;
        flows_open                = '0;
    endfunction

    // False for an early timestamp; restarts the window once it has run out.
    function automatic logic window_open(input logic [63:0] now);
        if (now < window_base)
            return 1'b0;
        if (now - window_base >= window_ns)
        begin
            window_base               = now;
            bytes_seen[INGRESS_DIR]   = '0;
            bytes_seen[EGRESS_DIR]    = '0;
            packets_seen[INGRESS_DIR] = '0;
            packets_seen[EGRESS_DIR]  = '0;
            flows_started             = '0;
            dns_spent                 = '0;
        end
        return 1'b1;
    endfunction

    // Byte budget first, then packet budget; counters move only when allowed.
    function automatic reason_t meter_traffic(input bit dir, input logic [63:0] now,
                                              input logic [63:0] len);
        if (!window_open(now))
            return REASON_BYTES;
        if (bytes_seen[dir] > byte_cap[dir] || len > byte_cap[dir] - bytes_seen[dir])
            return REASON_BYTES;
        if (packets_seen[dir] >= packet_cap[dir])
            return REASON_PACKETS;
        bytes_seen[dir]   = bytes_seen[dir] + len;
        packets_seen[dir] = packets_seen[dir] + 64'd1;
        return REASON_NONE;
    endfunction

    function automatic reason_t predicted_verdict(input event_t ev);
        reason_t     verdict;
        logic [63:0] len;
        logic        family_ok;
        logic        type_ok;
        verdict   = REASON_NONE;
        len       = {32'd0, ev.packet_length};
        family_ok = (ev.address_family == FAMILY_V4) || (ev.address_family == FAMILY_V6);
        type_ok   = (ev.socket_type == TYPE_STREAM) || (ev.socket_type == TYPE_DGRAM);
        unique case (ev.kind)
            KIND_INGRESS:
                verdict = meter_traffic(INGRESS_DIR, ev.timestamp_ns, len);
            KIND_EGRESS:
            begin
                // A DNS credit is taken before the traffic check and is never refunded.
                if (ev.remote_port == DNS_PORT)
                begin
                    if (window_open(ev.timestamp_ns) && dns_spent < dns_cap)
                        dns_spent = dns_spent + 64'd1;
                    else
                        verdict = REASON_DNS;
                end
                if (verdict == REASON_NONE)
                    verdict = meter_traffic(EGRESS_DIR, ev.timestamp_ns, len);
            end
            KIND_CREATE:
            begin
                if (!family_ok || !type_ok)
                    verdict = REASON_RAW;
                else if (window_open(ev.timestamp_ns) && flows_started < flow_cap &&
                         flows_open < open_cap)
                begin
                    flows_started = flows_started + 64'd1;
                    flows_open    = flows_open + 32'd1;
                    // A failed flow record gives back the open slot but not the credit.
                    if (!ev.flow_recorded)
                    begin
                        if (flows_open != 32'd0)
                            flows_open = flows_open - 32'd1;
                        verdict = REASON_FLOWS;
                    end
                end
                else
                    verdict = REASON_FLOWS;
            end
            KIND_RELEASE:
            begin
                if (ev.flow_tracked && flows_open != 32'd0)
                    flows_open = flows_open - 32'd1;
            end
        endcase
        return verdict;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        event_t  ev;
        result_t want;
        reason_t verdict;
        if (!rst_n)
        begin
            clear_accounting();
            awaited_verdicts.delete();
            errors = 0;
            mismatch_count  <= 0;
            results_pending <= 0;
        end
        else
        begin
            // Write registers only while the block is idle; the block does not check it.
            if (psel && penable && pwrite && pready)
            begin
                unique case (reg_idx_t'(paddr[PADDR_W-1:3]))
                    REG_INGRESS_BYTE_LIMIT:    byte_cap[INGRESS_DIR]   = pwdata;
                    REG_EGRESS_BYTE_LIMIT:     byte_cap[EGRESS_DIR]    = pwdata;
                    REG_INGRESS_PACKET_LIMIT:  packet_cap[INGRESS_DIR] = pwdata;
                    REG_EGRESS_PACKET_LIMIT:   packet_cap[EGRESS_DIR]  = pwdata;
                    REG_NEW_FLOW_LIMIT:        flow_cap                = pwdata;
                    REG_DNS_QUERY_LIMIT:       dns_cap                 = pwdata;
                    REG_CONCURRENT_FLOW_LIMIT: open_cap                = pwdata[31:0];
                    REG_WINDOW_LENGTH_NS:      window_ns               = pwdata;
                endcase
            end

            // Compare the result beat against the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no beat, actual allowed=%0d deny_code=%0d",
                             $time, m_axis_tdata[0], m_axis_tdata[3:1]);
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want.allowed)
                    begin
                        errors++;
                        $display("%0t: allowed mismatch, expected %0d actual %0d",
                                 $time, want.allowed, m_axis_tdata[0]);
                    end
                    if (m_axis_tdata[3:1] !== want.deny_code)
                    begin
                        errors++;
                        $display("%0t: deny_code mismatch, expected %0d actual %0d",
                                 $time, want.deny_code, m_axis_tdata[3:1]);
                    end
                end
            end

            // Predict the verdict of an accepted event beat.
            if (s_axis_tvalid && s_axis_tready)
            begin
                ev.kind           = kind_t'(s_axis_tuser[1:0]);
                ev.timestamp_ns   = s_axis_tdata[63:0];
                ev.packet_length  = s_axis_tdata[95:64];
                ev.remote_port    = s_axis_tdata[111:96];
                ev.address_family = s_axis_tdata[127:112];
                ev.socket_type    = s_axis_tdata[143:128];
                ev.flow_recorded  = s_axis_tdata[144];
                ev.flow_tracked   = s_axis_tdata[145];
                verdict           = predicted_verdict(ev);
                want.allowed      = (verdict == REASON_NONE);
                want.deny_code    = verdict;
                awaited_verdicts.push_back(want);
            end

            mismatch_count  <= errors;
            results_pending <= awaited_verdicts.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

// Drives events and register writes into the limiter, shapes the stream
// back-pressure, and reports the verdict of the checker.
module tb;
    import wtl_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned ITEMS_PER_PHASE = 210;
    localparam int unsigned COARSE_STRIDE = 268435456;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int          mismatch_count;
    int          results_pending;
    int unsigned quiet_cycles;
    int unsigned gap_pct;
    int unsigned stall_pct;
    logic [63:0] clock_ns;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    windowed_traffic_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wtl_verdict_checker verdict_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Result-side back-pressure follows the stall rate of the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Ends the run when no beat and no register access happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Setup phase, access phase, then the bus is released.
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_limits(input logic [63:0] in_bytes, input logic [63:0] out_bytes,
                                  input logic [63:0] in_pkts, input logic [63:0] out_pkts,
                                  input logic [63:0] flows, input logic [63:0] dns,
                                  input logic [31:0] open_flows, input logic [63:0] win);
        write_reg(REG_INGRESS_BYTE_LIMIT, in_bytes);
        write_reg(REG_EGRESS_BYTE_LIMIT, out_bytes);
        write_reg(REG_INGRESS_PACKET_LIMIT, in_pkts);
        write_reg(REG_EGRESS_PACKET_LIMIT, out_pkts);
        write_reg(REG_NEW_FLOW_LIMIT, flows);
        write_reg(REG_DNS_QUERY_LIMIT, dns);
        write_reg(REG_CONCURRENT_FLOW_LIMIT, {32'd0, open_flows});
        write_reg(REG_WINDOW_LENGTH_NS, win);
    endtask

    // Offers one event beat and returns at the edge where it is taken.
    task automatic offer_event(input kind_t k, input logic [63:0] ts, input logic [31:0] len,
                               input logic [15:0] port, input logic [15:0] fam,
                               input logic [15:0] typ, input logic rec, input logic trk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, trk, rec, typ, fam, port, len, ts};
        s_axis_tuser  <= k;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic on a rising clock, with some early stamps.
    task automatic offer_random_event(input int unsigned stride);
        int unsigned pick;
        kind_t       k;
        logic [63:0] ts;
        logic [31:0] len;
        logic [15:0] port;
        logic [15:0] fam;
        logic [15:0] typ;
        pick = $urandom_range(99);
        if (pick < 30)
            k = KIND_INGRESS;
        else if (pick < 60)
            k = KIND_EGRESS;
        else if (pick < 82)
            k = KIND_CREATE;
        else
            k = KIND_RELEASE;
        clock_ns = clock_ns + 64'($urandom_range(stride));
        ts = clock_ns;
        if ($urandom_range(99) < 6)
            ts = (clock_ns > 64'd5000) ? clock_ns - 64'($urandom_range(1, 5000)) : 64'd0;
        pick = $urandom_range(99);
        if (pick < 90)
            len = $urandom_range(1500);
        else if (pick < 97)
            len = $urandom;
        else
            len = 32'hFFFF_FFFF;
        port = ($urandom_range(99) < 35) ? DNS_PORT : 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 85)
            fam = $urandom_range(1) ? FAMILY_V6 : FAMILY_V4;
        else
            fam = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 85)
            typ = $urandom_range(1) ? TYPE_DGRAM : TYPE_STREAM;
        else
            typ = 16'($urandom_range(16'hFFFF));
        offer_event(k, ts, len, port, fam, typ, $urandom_range(99) < 85,
                    1'($urandom_range(1)));
    endtask

    // Drops the sender's valid and holds it until every verdict is back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_traffic(input int unsigned idle_pct, input int unsigned busy_pct,
                               input int unsigned stride);
        gap_pct   = idle_pct;
        stall_pct = busy_pct;
        repeat (ITEMS_PER_PHASE) offer_random_event(stride);
        wait_drained();
    endtask

    initial
    begin
        logic [63:0] jump;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_INGRESS;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        gap_pct   = 0;
        stall_pct = 0;
        clock_ns  = 64'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset limits of zero, packets and creates are refused.
        offer_event(KIND_INGRESS, 64'd10, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_CREATE, 64'd20, 32'd0, 16'd0, FAMILY_V4, TYPE_STREAM, 1'b1, 1'b0);
        wait_drained();

        // Tight budgets to walk through every reason by hand.
        program_limits(64'd3000, 64'd3000, 64'd3, 64'd3, 64'd3, 64'd1, 32'd2, 64'd1000);
        offer_event(KIND_INGRESS, 64'd100, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_INGRESS, 64'd100, 32'd3000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_INGRESS, 64'd101, 32'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd102, 32'd10, DNS_PORT, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd103, 32'd10, DNS_PORT, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd104, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1);
        offer_event(KIND_EGRESS, 64'd105, 32'd100, 16'd80, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd106, 32'd100, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd107, 32'd0, 16'd80, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_CREATE, 64'd108, 32'd0, 16'd0, 16'hFFFF, TYPE_STREAM, 1'b1, 1'b0);
        offer_event(KIND_CREATE, 64'd109, 32'd0, 16'd0, FAMILY_V4, 16'hFFFF, 1'b1, 1'b0);
        offer_event(KIND_CREATE, 64'd110, 32'd0, 16'd0, FAMILY_V6, TYPE_DGRAM, 1'b0, 1'b0);
        offer_event(KIND_CREATE, 64'd111, 32'd0, 16'd0, FAMILY_V4, TYPE_STREAM, 1'b1, 1'b0);
        offer_event(KIND_CREATE, 64'd112, 32'd0, 16'd0, FAMILY_V6, TYPE_STREAM, 1'b1, 1'b0);
        offer_event(KIND_CREATE, 64'd113, 32'd0, 16'd0, FAMILY_V4, TYPE_DGRAM, 1'b1, 1'b0);
        offer_event(KIND_RELEASE, 64'd114, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_RELEASE, 64'd115, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
        offer_event(KIND_RELEASE, 64'd116, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
        offer_event(KIND_RELEASE, 64'd117, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
        // Window rollover, then stamps from before the new window start.
        offer_event(KIND_INGRESS, 64'd1200, 32'd5, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_INGRESS, 64'd0, 32'd5, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_EGRESS, 64'd5, 32'd5, DNS_PORT, 16'd0, 16'd0, 1'b0, 1'b0);
        offer_event(KIND_CREATE, 64'd7, 32'd0, 16'd0, FAMILY_V4, TYPE_STREAM, 1'b1, 1'b0);
        wait_drained();
        clock_ns = 64'd1300;

        // Short windows with budgets that run out often, no idling.
        program_limits(64'd20000, 64'd20000, 64'd12, 64'd12, 64'd6, 64'd3, 32'd3, 64'd400);
        run_traffic(0, 0, 40);

        // Every budget wide open and a window that never runs out.
        program_limits(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                       32'hFFFF_FFFF, ALL_ONES);
        run_traffic(80, 0, 1000);

        // Every budget closed and the shortest nonzero window.
        program_limits(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0, 64'd1);
        run_traffic(0, 80, 50);

        // Small budgets after a jump forward in time.
        jump = {$urandom, $urandom};
        clock_ns = clock_ns + (jump >> 20);
        program_limits(64'd4000, 64'd6000, 64'd5, 64'd7, 64'd4, 64'd2, 32'd2, 64'd1000);
        run_traffic(22, 22, 100);

        // Random budgets at timestamps with the top bit set.
        jump = {$urandom, $urandom};
        clock_ns = {3'b100, jump[60:0]};
        program_limits(64'($urandom_range(500, 8000)), 64'($urandom_range(500, 8000)),
                       64'($urandom_range(1, 6)), 64'($urandom_range(1, 6)),
                       64'($urandom_range(1, 4)), 64'($urandom_range(1, 3)),
                       $urandom_range(1, 5), DEFAULT_WINDOW_NS);
        run_traffic(0, 0, COARSE_STRIDE);

        // Mixed extremes, then one event at the last representable time.
        program_limits(ALL_ONES, {32'd0, $urandom}, 64'($urandom_range(3, 10)), ALL_ONES,
                       ALL_ONES, 64'd0, 32'hFFFF_FFFF, DEFAULT_WINDOW_NS);
        run_traffic(22, 22, COARSE_STRIDE);
        offer_event(KIND_EGRESS, ALL_ONES, 32'd64, DNS_PORT, 16'd0, 16'd0, 1'b0, 1'b0);
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/wtl_pkg.sv
design/wtl_cfg_regs.sv
design/wtl_engine.sv
design/windowed_traffic_limiter.sv
design/wtl_checker.sv
dv/wtl_verdict_checker.sv
dv/tb.sv
